[hdl/sdt_pkg.sv]
`timescale 1ns / 1ps
package sdt_pkg;

    // input coordinate width (vertex fields)
    localparam int COORD_BITS = 24;
    localparam int EYE_W      = 24;
    localparam int TIME_W     = 32;
    localparam int OUT_W      = 32;
    localparam int CFG_W      = 32;
    localparam int IDX_W      = 2;

    // derived datapath widths
    localparam int DIFF_W = ((COORD_BITS > EYE_W) ? COORD_BITS : EYE_W) + 1;
    localparam int FZ_W   = DIFF_W + 2;          // 6 * |dz|
    localparam int SUM_W  = 2 * DIFF_W + 4;      // dx^2 + dy^2 + (6dz)^2
    localparam int LEN_W  = DIFF_W + 2;          // floor(sqrt(sum))
    localparam int NUM_W  = DIFF_W + 9;          // |d| * 378
    localparam int QUO_W  = 25;                  // |h| <= 378 * 2^16
    localparam int H_W    = QUO_W + 1;
    localparam int U_W    = TIME_W + 8;          // 16*T + h, signed
    localparam int FRAC_SH = 16;
    localparam int SKY_SCALE = 378;

    // result queue
    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int RES_W      = 4 * OUT_W;

    typedef enum logic [IDX_W-1:0] {
        REG_EYE_X       = 2'd0,
        REG_EYE_Y       = 2'd1,
        REG_EYE_Z       = 2'd2,
        REG_SCROLL_TIME = 2'd3
    } t_reg_idx;

    // front to length pipeline
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [NUM_W-1:0] nx;
        logic [NUM_W-1:0] ny;
        logic             sx;
        logic             sy;
    } t_sq_beat;

    // length pipeline to dividers
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [NUM_W-1:0] nx;
        logic [NUM_W-1:0] ny;
        logic             sx;
        logic             sy;
    } t_len_beat;

endpackage

[hdl/sky_dome_texcoord_gen.sv]
`timescale 1ns / 1ps
// Pipeline: an accepted vertex passes 3 front, 28 square root and 26 divider stages
// and then the queue head register, the first stage loaded at the accepting edge.
// Throughput: one vertex per cycle while full is low; credits cover every vertex
// accepted and not yet popped, so full rises only when 64 such vertices exist.
// Reset (synchronous, active low) clears the eye and time registers to zero,
// empties the queue and drops all work in flight.
module sky_dome_texcoord_gen
    import sdt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [COORD_BITS-1:0] i_vertex_x,
    input  logic [COORD_BITS-1:0] i_vertex_y,
    input  logic [COORD_BITS-1:0] i_vertex_z,
    output logic                  empty,
    input  logic                  pop,
    output logic [OUT_W-1:0]      o_base_s,
    output logic [OUT_W-1:0]      o_base_t,
    output logic [OUT_W-1:0]      o_overlay_s,
    output logic [OUT_W-1:0]      o_overlay_t,
    input  logic                  i_cfg_we,
    input  logic [IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    logic [EYE_W-1:0]  r_eye_x, r_eye_y, r_eye_z;
    logic [TIME_W-1:0] r_time;
    logic [CNT_W-1:0]  r_credit;

    logic      acc, pop_fire;
    logic      f_valid, l_valid, dx_valid, dy_valid;
    t_sq_beat  f_beat;
    t_len_beat l_beat;
    logic signed [H_W-1:0] hx, hy;
    logic [RES_W-1:0] wdata, rdata;
    logic [U_W-1:0]   t8, t16;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye_x <= '0;
            r_eye_y <= '0;
            r_eye_z <= '0;
            r_time  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_EYE_X:       r_eye_x <= i_cfg_data[EYE_W-1:0];
                REG_EYE_Y:       r_eye_y <= i_cfg_data[EYE_W-1:0];
                REG_EYE_Z:       r_eye_z <= i_cfg_data[EYE_W-1:0];
                REG_SCROLL_TIME: r_time  <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // credits cover everything in flight plus queued results
    assign acc      = push && !full;
    assign pop_fire = pop && !empty;
    assign full     = (r_credit == CNT_W'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CNT_W'(acc) - CNT_W'(pop_fire);
        end
    end

    sdt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc),
        .i_vx    (i_vertex_x),
        .i_vy    (i_vertex_y),
        .i_vz    (i_vertex_z),
        .i_eye_x (r_eye_x),
        .i_eye_y (r_eye_y),
        .i_eye_z (r_eye_z),
        .o_valid (f_valid),
        .o_beat  (f_beat)
    );

    sdt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_beat  (f_beat),
        .o_valid (l_valid),
        .o_beat  (l_beat)
    );

    sdt_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (l_valid),
        .i_len   (l_beat.len),
        .i_num   (l_beat.nx),
        .i_neg   (l_beat.sx),
        .o_valid (dx_valid),
        .o_h     (hx)
    );

    sdt_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (l_valid),
        .i_len   (l_beat.len),
        .i_num   (l_beat.ny),
        .i_neg   (l_beat.sy),
        .o_valid (dy_valid),
        .o_h     (hy)
    );

    // floor((k*T + h) / 128) mod 2^32
    function automatic logic [OUT_W-1:0] layer(input logic [U_W-1:0] t,
                                               input logic signed [H_W-1:0] h);
        logic [U_W-1:0] u;
        u = t + U_W'(h);
        return u[OUT_W+6:7];
    endfunction

    assign t8    = U_W'(r_time) << 3;
    assign t16   = U_W'(r_time) << 4;
    assign wdata = {layer(t8, hx), layer(t8, hy), layer(t16, hx), layer(t16, hy)};

    sdt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (dx_valid),
        .i_wdata (wdata),
        .i_rd    (pop),
        .o_empty (empty),
        .o_rdata (rdata)
    );

    assign o_base_s    = rdata[4*OUT_W-1:3*OUT_W];
    assign o_base_t    = rdata[3*OUT_W-1:2*OUT_W];
    assign o_overlay_s = rdata[2*OUT_W-1:OUT_W];
    assign o_overlay_t = rdata[OUT_W-1:0];

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dx_valid == dy_valid)
        else $error("divider lanes out of step");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CNT_W'(FIFO_DEPTH))
        else $error("credit count out of range");

    a_credit_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !pop_fire) |=> (r_credit == $past(r_credit) + CNT_W'(1)))
        else $error("credit not taken for accepted vertex");

    a_result_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_credit != '0))
        else $error("result queued without credit");

endmodule

[hdl/sdt_front.sv]
`timescale 1ns / 1ps
module sdt_front
    import sdt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [COORD_BITS-1:0] i_vx,
    input  logic [COORD_BITS-1:0] i_vy,
    input  logic [COORD_BITS-1:0] i_vz,
    input  logic [EYE_W-1:0]      i_eye_x,
    input  logic [EYE_W-1:0]      i_eye_y,
    input  logic [EYE_W-1:0]      i_eye_z,
    output logic                  o_valid,
    output t_sq_beat              o_beat
);

    logic                     r_v1, r_v2, r_v3;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic [2*DIFF_W-1:0]      r_sqx, r_sqy;
    logic [2*FZ_W-1:0]        r_sqz;
    logic [NUM_W-1:0]         r_nx2, r_ny2;
    logic                     r_sx2, r_sy2;
    t_sq_beat                 r_beat;

    logic [DIFF_W-1:0] ax, ay, az;
    logic [FZ_W-1:0]   fz;

    // sign extend both sides to the difference width
    function automatic logic signed [DIFF_W-1:0] diff(input logic [COORD_BITS-1:0] v,
                                                      input logic [EYE_W-1:0] e);
        logic signed [DIFF_W-1:0] a, b;
        a = $signed({{(DIFF_W-COORD_BITS){v[COORD_BITS-1]}}, v});
        b = $signed({{(DIFF_W-EYE_W){e[EYE_W-1]}}, e});
        return a - b;
    endfunction

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // magnitudes; vertical axis flattened by 6
    assign ax = r_dx[DIFF_W-1] ? DIFF_W'(-r_dx) : DIFF_W'(r_dx);
    assign ay = r_dy[DIFF_W-1] ? DIFF_W'(-r_dy) : DIFF_W'(r_dy);
    assign az = r_dz[DIFF_W-1] ? DIFF_W'(-r_dz) : DIFF_W'(r_dz);
    assign fz = (FZ_W'(az) << 2) + (FZ_W'(az) << 1);

    // stage 1: differences, stage 2: products, stage 3: sum of squares
    always_ff @(posedge i_clk) begin
        r_dx <= diff(i_vx, i_eye_x);
        r_dy <= diff(i_vy, i_eye_y);
        r_dz <= diff(i_vz, i_eye_z);

        r_sqx <= (2*DIFF_W)'(ax) * (2*DIFF_W)'(ax);
        r_sqy <= (2*DIFF_W)'(ay) * (2*DIFF_W)'(ay);
        r_sqz <= (2*FZ_W)'(fz) * (2*FZ_W)'(fz);
        r_nx2 <= NUM_W'(ax) * NUM_W'(SKY_SCALE);
        r_ny2 <= NUM_W'(ay) * NUM_W'(SKY_SCALE);
        r_sx2 <= r_dx[DIFF_W-1];
        r_sy2 <= r_dy[DIFF_W-1];

        r_beat.sum <= SUM_W'(r_sqx) + SUM_W'(r_sqy) + SUM_W'(r_sqz);
        r_beat.nx  <= r_nx2;
        r_beat.ny  <= r_ny2;
        r_beat.sx  <= r_sx2;
        r_beat.sy  <= r_sy2;
    end

    assign o_valid = r_v3;
    assign o_beat  = r_beat;

endmodule

[hdl/sdt_sqrt.sv]
`timescale 1ns / 1ps
module sdt_sqrt
    import sdt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_sq_beat  i_beat,
    output logic      o_valid,
    output t_len_beat o_beat
);

    localparam int TW = SUM_W + 2;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [LEN_W-1:0] root;
        logic [SUM_W-1:0] sq;     // root * root
        logic [NUM_W-1:0] nx;
        logic [NUM_W-1:0] ny;
        logic             sx;
        logic             sy;
    } t_sqrt_st;

    logic     r_v  [0:LEN_W];
    t_sqrt_st r_st [0:LEN_W];

    // stage 0 loads the operand
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0].sum  <= i_beat.sum;
        r_st[0].root <= '0;
        r_st[0].sq   <= '0;
        r_st[0].nx   <= i_beat.nx;
        r_st[0].ny   <= i_beat.ny;
        r_st[0].sx   <= i_beat.sx;
        r_st[0].sy   <= i_beat.sy;
    end

    // one root bit per stage, most significant first
    for (genvar i = 0; i < LEN_W; i++) begin : g_stage
        localparam int B = LEN_W - 1 - i;
        logic [TW-1:0] trial;
        logic          take;

        // (r + 2^B)^2 = r^2 + r*2^(B+1) + 2^(2B)
        assign trial = TW'(r_st[i].sq) + (TW'(r_st[i].root) << (B + 1))
                     + (TW'(1) << (2 * B));
        assign take  = (trial <= TW'(r_st[i].sum));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[i+1]      <= r_st[i];
            if (take) begin
                r_st[i+1].root <= r_st[i].root | (LEN_W'(1) << B);
                r_st[i+1].sq   <= trial[SUM_W-1:0];
            end
        end
    end

    assign o_valid     = r_v[LEN_W];
    assign o_beat.len  = r_st[LEN_W].root;
    assign o_beat.nx   = r_st[LEN_W].nx;
    assign o_beat.ny   = r_st[LEN_W].ny;
    assign o_beat.sx   = r_st[LEN_W].sx;
    assign o_beat.sy   = r_st[LEN_W].sy;

endmodule

[hdl/sdt_div.sv]
`timescale 1ns / 1ps
module sdt_div
    import sdt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [LEN_W-1:0]      i_len,
    input  logic [NUM_W-1:0]      i_num,
    input  logic                  i_neg,
    output logic                  o_valid,
    output logic signed [H_W-1:0] o_h
);

    localparam int RW = NUM_W + FRAC_SH + LEN_W;

    typedef struct packed {
        logic [RW-1:0]    rem;
        logic [LEN_W-1:0] len;
        logic [QUO_W-1:0] quo;
        logic             neg;
    } t_div_st;

    logic    r_v  [0:QUO_W];
    t_div_st r_st [0:QUO_W];
    logic [QUO_W-1:0] q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    // numerator is |d| * 378 in Q.16 (extra 16 fraction bits)
    always_ff @(posedge i_clk) begin
        r_st[0].rem <= RW'(i_num) << FRAC_SH;
        r_st[0].len <= i_len;
        r_st[0].quo <= '0;
        r_st[0].neg <= i_neg;
    end

    // restoring division, one quotient bit per stage
    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        localparam int K = QUO_W - 1 - i;
        logic [RW-1:0] den;
        logic          take;

        assign den  = RW'(r_st[i].len) << K;
        assign take = (r_st[i].rem >= den);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[i+1] <= r_st[i];
            if (take) begin
                r_st[i+1].rem <= r_st[i].rem - den;
                r_st[i+1].quo <= r_st[i].quo | (QUO_W'(1) << K);
            end
        end
    end

    // zero length gives zero scale; apply sign
    assign q       = (r_st[QUO_W].len == '0) ? '0 : r_st[QUO_W].quo;
    assign o_valid = r_v[QUO_W];
    assign o_h     = r_st[QUO_W].neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

endmodule

[hdl/sdt_fifo.sv]
`timescale 1ns / 1ps
module sdt_fifo
    import sdt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [RES_W-1:0] i_wdata,
    input  logic             i_rd,
    output logic             o_empty,
    output logic [RES_W-1:0] o_rdata
);

    logic [RES_W-1:0] r_mem [0:FIFO_DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [RES_W-1:0] r_head;
    logic             rd_fire;

    assign rd_fire  = i_rd && (r_count != '0);
    assign n_rd_ptr = r_rd_ptr + PTR_W'(rd_fire);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_wr);
            r_rd_ptr <= n_rd_ptr;
            r_count  <= r_count + CNT_W'(i_wr) - CNT_W'(rd_fire);
        end
    end

    // storage, head register read ahead with write bypass
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
        if (i_wr && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_wdata;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    assign o_empty = (r_count == '0);
    assign o_rdata = r_head;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (r_count < CNT_W'(FIFO_DEPTH) || rd_fire))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_pop_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd && o_empty) |=> (r_rd_ptr == $past(r_rd_ptr)))
        else $error("read pointer moved on empty queue");

endmodule
